// ===== rtl/hma_pkg.sv =====
// ----------------------------------------------------------------------------
// hma_pkg
// Shared types, constants and plan tables for the hysteresis mode arbiter.
// ----------------------------------------------------------------------------
`default_nettype none

package hma_pkg;

  localparam int unsigned FrameMs = 100;
  localparam int unsigned DtMax   = 4 * FrameMs;
  localparam int unsigned DtW     = $clog2(DtMax + 1);
  localparam int unsigned QDepth  = 2;
  localparam int unsigned QAw     = $clog2(QDepth);
  localparam int unsigned QCw     = $clog2(QDepth + 1);
  localparam int unsigned NumDwell = 5;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;

  localparam int unsigned DwLatEnter = 0;
  localparam int unsigned DwLatExit  = 1;
  localparam int unsigned DwThEnter  = 2;
  localparam int unsigned DwThExit   = 3;
  localparam int unsigned DwBoth     = 4;

  typedef enum logic [1:0] {
    MODE_NORMAL   = 2'd0,
    MODE_LATENCY  = 2'd1,
    MODE_THERMAL  = 2'd2,
    MODE_DEGRADED = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_LAT_ENTER = 3'd0,
    CFG_LAT_EXIT  = 3'd1,
    CFG_TH_ENTER  = 3'd2,
    CFG_TH_EXIT   = 3'd3,
    CFG_HOLD      = 3'd4,
    CFG_LOCKOUT   = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] lat_enter;
    logic [15:0] lat_exit;
    logic [15:0] th_enter;
    logic [15:0] th_exit;
    logic [31:0] hold;
    logic [31:0] lockout;
  } cfg_t;

  typedef struct packed {
    logic [47:0] time_ms;
    logic        sample_valid;
    logic [15:0] lat_sample;
    logic [15:0] thermal_level;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  mode_now;
    logic        mode_changed;
    logic        lockout_held;
    logic [1:0]  energy_pref;
    logic [6:0]  perf_floor;
    logic        present_fifo;
    logic        use_scaler;
    logic [31:0] transition_count;
    logic [31:0] lockout_hold_count;
  } out_word_t;

  typedef struct packed {
    logic [47:0]    time_ms;
    logic           sample_valid;
    logic [DtW-1:0] dt;
    logic           lat_hi;
    logic           lat_lo;
    logic           th_hi;
    logic           th_lo;
  } cls_word_t;

  function automatic logic [6:0] plan_perf(mode_e m);
    logic [6:0] p;
    unique case (m)
      MODE_NORMAL:   p = 7'd25;
      MODE_LATENCY:  p = 7'd70;
      MODE_THERMAL:  p = 7'd30;
      MODE_DEGRADED: p = 7'd10;
      default:       p = 7'd25;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/hma_front.sv =====
// ----------------------------------------------------------------------------
// hma_front
// Accepts sample words, derives the clamped elapsed time and classifies the
// samples against the enter and exit levels.
// ----------------------------------------------------------------------------
`default_nettype none

module hma_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire hma_pkg::cfg_t     cfg_i,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire hma_pkg::in_word_t in_word_i,
  input  wire logic              q_full_i,
  output logic                   q_push_o,
  output hma_pkg::cls_word_t     q_word_o
);

  logic [47:0] last_time_q, last_time_d;
  logic [47:0] raw_dt;

  assign in_stall_o = q_full_i;
  assign q_push_o   = in_valid_i && !q_full_i;
  assign raw_dt     = in_word_i.time_ms - last_time_q;

  always_comb begin
    last_time_d = q_push_o ? in_word_i.time_ms : last_time_q;

    q_word_o.time_ms      = in_word_i.time_ms;
    q_word_o.sample_valid = in_word_i.sample_valid;
    if (in_word_i.time_ms <= last_time_q) begin
      q_word_o.dt = '0;
    end else if (raw_dt > 48'(hma_pkg::DtMax)) begin
      q_word_o.dt = hma_pkg::DtW'(hma_pkg::DtMax);
    end else begin
      q_word_o.dt = raw_dt[hma_pkg::DtW-1:0];
    end
    q_word_o.lat_hi = in_word_i.lat_sample > cfg_i.lat_enter;
    q_word_o.lat_lo = in_word_i.lat_sample < cfg_i.lat_exit;
    q_word_o.th_hi  = in_word_i.thermal_level > cfg_i.th_enter;
    q_word_o.th_lo  = in_word_i.thermal_level < cfg_i.th_exit;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_time_q <= '0;
    end else begin
      last_time_q <= last_time_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hma_queue.sv =====
// ----------------------------------------------------------------------------
// hma_queue
// Two-entry queue of classified words between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module hma_queue (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire hma_pkg::cls_word_t push_word_i,
  output logic                    full_o,
  input  wire logic               pop_i,
  output logic                    valid_o,
  output hma_pkg::cls_word_t      pop_word_o
);

  hma_pkg::cls_word_t           mem_q [hma_pkg::QDepth];
  logic [hma_pkg::QAw-1:0]      wr_ptr_q, wr_ptr_d;
  logic [hma_pkg::QAw-1:0]      rd_ptr_q, rd_ptr_d;
  logic [hma_pkg::QCw-1:0]      count_q, count_d;

  assign full_o     = count_q == hma_pkg::QCw'(hma_pkg::QDepth);
  assign valid_o    = count_q != '0;
  assign pop_word_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= hma_pkg::QCw'(hma_pkg::QDepth))
    else $error("queue count exceeds depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(pop_i && !valid_o) && !(push_i && full_o))
    else $error("queue underflow or overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_i && !pop_i) |=> count_q == $past(count_q) + 1'b1)
    else $error("queue count did not follow a push");

endmodule

`default_nettype wire

// ===== rtl/hma_back.sv =====
// ----------------------------------------------------------------------------
// hma_back
// Updates the dwell timers, applies the lockout and mode rules, and holds
// the result word until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hma_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire hma_pkg::cfg_t      cfg_i,
  input  wire logic               q_valid_i,
  input  wire hma_pkg::cls_word_t q_word_i,
  output logic                    q_pop_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output hma_pkg::out_word_t      out_word_o
);

  hma_pkg::mode_e      mode_q, mode_d, target;
  logic [47:0]         lockout_q, lockout_d;
  logic [31:0]         dwell_q [hma_pkg::NumDwell];
  logic [31:0]         dwell_d [hma_pkg::NumDwell];
  logic [31:0]         dwell_upd [hma_pkg::NumDwell];
  logic [hma_pkg::NumDwell-1:0] pred;
  logic [32:0]         dwell_sum [hma_pkg::NumDwell];
  logic [31:0]         trans_q, trans_d;
  logic [31:0]         holds_q, holds_d;
  logic                held, changed;
  logic                out_valid_q;
  hma_pkg::out_word_t  out_q, out_d;

  assign q_pop_o     = q_valid_i && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  always_comb begin
    pred[hma_pkg::DwLatEnter] = q_word_i.lat_hi;
    pred[hma_pkg::DwLatExit]  = q_word_i.lat_lo;
    pred[hma_pkg::DwThEnter]  = q_word_i.th_hi;
    pred[hma_pkg::DwThExit]   = q_word_i.th_lo;
    pred[hma_pkg::DwBoth]     = q_word_i.lat_lo && q_word_i.th_lo;
    for (int i = 0; i < hma_pkg::NumDwell; i++) begin
      dwell_sum[i] = {1'b0, dwell_q[i]} + 33'(q_word_i.dt);
      if (!pred[i]) begin
        dwell_upd[i] = '0;
      end else if (dwell_sum[i][32]) begin
        dwell_upd[i] = '1;
      end else begin
        dwell_upd[i] = dwell_sum[i][31:0];
      end
    end

    target = mode_q;
    unique case (mode_q)
      hma_pkg::MODE_NORMAL: begin
        if (q_word_i.th_hi && dwell_upd[hma_pkg::DwThEnter] >= cfg_i.hold) begin
          target = hma_pkg::MODE_THERMAL;
        end else if (q_word_i.lat_hi && dwell_upd[hma_pkg::DwLatEnter] >= cfg_i.hold) begin
          target = hma_pkg::MODE_LATENCY;
        end
      end
      hma_pkg::MODE_LATENCY: begin
        if (q_word_i.th_hi) begin
          target = hma_pkg::MODE_THERMAL;
        end else if (q_word_i.lat_lo && dwell_upd[hma_pkg::DwLatExit] >= cfg_i.hold) begin
          target = hma_pkg::MODE_NORMAL;
        end
      end
      hma_pkg::MODE_THERMAL: begin
        if (q_word_i.th_lo && dwell_upd[hma_pkg::DwThExit] >= cfg_i.hold) begin
          target = hma_pkg::MODE_NORMAL;
        end else if (q_word_i.lat_hi && !q_word_i.th_lo &&
                     dwell_upd[hma_pkg::DwLatEnter] >= cfg_i.hold) begin
          target = hma_pkg::MODE_DEGRADED;
        end
      end
      hma_pkg::MODE_DEGRADED: begin
        if (dwell_upd[hma_pkg::DwBoth] >= cfg_i.hold) begin
          target = hma_pkg::MODE_NORMAL;
        end
      end
      default: target = mode_q;
    endcase

    held    = q_word_i.sample_valid && (q_word_i.time_ms < lockout_q);
    changed = q_word_i.sample_valid && !held && (target != mode_q);

    mode_d    = mode_q;
    lockout_d = lockout_q;
    trans_d   = trans_q;
    holds_d   = holds_q;
    for (int i = 0; i < hma_pkg::NumDwell; i++) begin
      dwell_d[i] = dwell_q[i];
    end
    if (q_pop_o && q_word_i.sample_valid) begin
      for (int i = 0; i < hma_pkg::NumDwell; i++) begin
        dwell_d[i] = changed ? '0 : dwell_upd[i];
      end
      if (held) begin
        holds_d = holds_q + 32'd1;
      end
      if (changed) begin
        mode_d    = target;
        lockout_d = q_word_i.time_ms + 48'(cfg_i.lockout);
        trans_d   = trans_q + 32'd1;
      end
    end

    out_d.mode_now           = mode_d;
    out_d.mode_changed       = changed;
    out_d.lockout_held       = held;
    out_d.energy_pref        = mode_d;
    out_d.perf_floor         = hma_pkg::plan_perf(mode_d);
    out_d.present_fifo       = mode_d == hma_pkg::MODE_DEGRADED;
    out_d.use_scaler         = mode_d == hma_pkg::MODE_DEGRADED;
    out_d.transition_count   = trans_d;
    out_d.lockout_hold_count = holds_d;
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= hma_pkg::MODE_NORMAL;
      lockout_q   <= '0;
      trans_q     <= '0;
      holds_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < hma_pkg::NumDwell; i++) begin
        dwell_q[i] <= '0;
      end
    end else begin
      mode_q    <= mode_d;
      lockout_q <= lockout_d;
      trans_q   <= trans_d;
      holds_q   <= holds_d;
      if (q_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      for (int i = 0; i < hma_pkg::NumDwell; i++) begin
        dwell_q[i] <= dwell_d[i];
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/hysteresis_mode_arbiter.sv =====
// ----------------------------------------------------------------------------
// hysteresis_mode_arbiter
// Four-mode arbiter with dwell-time hysteresis and post-transition lockout.
// ----------------------------------------------------------------------------
// The block takes one sample word per clock cycle while the input is not
// stalled and returns exactly one result word for each, in order. An
// accepted word is classified and placed in a two-entry queue; the back end
// takes it from the queue, updating the dwell timers and the mode in a single
// step, and registers the result word, which it offers until it is taken. The
// single-step back-end update and the queue set the sustained rate of one
// word per cycle while the output side keeps up; while the output is stalled
// the queue fills and the input stalls once two words wait there.
// Configuration registers should be written only while no word is in flight.
`default_nettype none

module hysteresis_mode_arbiter (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [hma_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [hma_pkg::CfgDataW-1:0]    cfg_data_i,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire hma_pkg::in_word_t               in_word_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output hma_pkg::out_word_t                   out_word_o
);

  hma_pkg::cfg_t      cfg_q;
  logic               q_full, q_push, q_pop, q_valid;
  hma_pkg::cls_word_t push_word, pop_word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        hma_pkg::CFG_LAT_ENTER: cfg_q.lat_enter <= cfg_data_i[15:0];
        hma_pkg::CFG_LAT_EXIT:  cfg_q.lat_exit  <= cfg_data_i[15:0];
        hma_pkg::CFG_TH_ENTER:  cfg_q.th_enter  <= cfg_data_i[15:0];
        hma_pkg::CFG_TH_EXIT:   cfg_q.th_exit   <= cfg_data_i[15:0];
        hma_pkg::CFG_HOLD:      cfg_q.hold      <= cfg_data_i;
        hma_pkg::CFG_LOCKOUT:   cfg_q.lockout   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  hma_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_word_i  (in_word_i),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_word_o   (push_word)
  );

  hma_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (q_push),
    .push_word_i (push_word),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .pop_word_o  (pop_word)
  );

  hma_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_word_i    (pop_word),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

endmodule

`default_nettype wire
